### rtl/eil_pkg.sv
// Shared types, codes and defaults for the exon interval locator.
package eil_pkg;

	localparam int MAX_EXONS_DEF = 512;

	// Configuration register indexes.
	localparam logic [2:0] CFG_REVERSE    = 3'd0;
	localparam logic [2:0] CFG_CHROM      = 3'd1;
	localparam logic [2:0] CFG_TX_START   = 3'd2;
	localparam logic [2:0] CFG_TX_END     = 3'd3;
	localparam logic [2:0] CFG_CDS_START  = 3'd4;
	localparam logic [2:0] CFG_CDS_END    = 3'd5;
	localparam logic [2:0] CFG_EXON_COUNT = 3'd6;

	// Item function codes.
	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_SECTOR = 2'd1;
	localparam logic [1:0] FUNC_CODING = 2'd2;

	// Region kinds of a sector query.
	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_FIVE   = 3'd1;
	localparam logic [2:0] KIND_THREE  = 3'd2;
	localparam logic [2:0] KIND_EXON   = 3'd3;
	localparam logic [2:0] KIND_INTRON = 3'd4;

	// Status codes of a coding query.
	localparam logic [1:0] MAP_OK       = 2'd0;
	localparam logic [1:0] MAP_NO_START = 2'd1;
	localparam logic [1:0] MAP_BEYOND   = 2'd2;

	// Operands of the shared step unit.
	typedef struct packed {
		logic [32:0] point;
		logic [31:0] a_lo;
		logic [31:0] a_hi;
		logic [31:0] b_lo;
		logic [31:0] b_hi;
	} step_req_t;

	// Results of the shared step unit.
	typedef struct packed {
		logic        hit_a;
		logic        hit_b;
		logic        fits;
		logic [31:0] pos_up;
		logic [31:0] pos_down;
	} step_rsp_t;

endpackage

### rtl/eil_step_unit.sv
// Shared window-compare and span arithmetic used on every table entry.
module eil_step_unit #(
	parameter int KW = 43
) (
	input  eil_pkg::step_req_t req,
	input  logic [KW-1:0]      k,
	output eil_pkg::step_rsp_t rsp,
	output logic [KW-1:0]      k_next
);
	import eil_pkg::*;

	logic [32:0]          span33;
	logic signed [KW-1:0] span_w;

	// Span of the current entry, sign-extended to the offset width.
	assign span33 = {1'b0, req.a_hi} - {1'b0, req.a_lo};
	assign span_w = {{(KW-33){span33[32]}}, span33};

	always_comb begin
		rsp.hit_a    = (req.point > {1'b0, req.a_lo}) && (req.point <= {1'b0, req.a_hi});
		rsp.hit_b    = (req.point > {1'b0, req.b_lo}) && (req.point <= {1'b0, req.b_hi});
		rsp.fits     = $signed(k) < span_w;
		rsp.pos_up   = req.a_lo + k[31:0] + 32'd1;
		rsp.pos_down = req.a_hi - k[31:0];
	end

	assign k_next = k - span_w;

endmodule

### rtl/exon_interval_locator_core.sv
// Top level of the exon interval locator: registers, exon table, walk sequencer.
//
//  channel   direction  handshake                    contents
//  config    in         cfg_write_en                 cfg_index, cfg_data
//  item      in         item_valid / item_stall      func and query or load fields
//  result    out        result_valid / result_stall  region, position and status
//
// A load item gives no result. A query walks the exon table one entry per
// cycle through the single read port of the table memory, with the exon
// count capped at the table size; a sector query decided by the chromosome
// or transcript bounds goes to its result without walking the table. The
// next item is taken in the cycle after the result is loaded, and loading
// waits while a stalled result still holds the output register. Reset
// clears the control state, the output valid and the configuration
// registers, but not the table, whose entries are undefined until loaded.
module exon_interval_locator_core #(
	parameter int MAX_EXONS = eil_pkg::MAX_EXONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  func,
	input  logic [8:0]  exon_slot,
	input  logic [31:0] exon_begin,
	input  logic [31:0] exon_finish,
	input  logic [7:0]  query_chrom,
	input  logic [31:0] query_position,
	input  logic [31:0] coding_index,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  region_kind,
	output logic [9:0]  region_number,
	output logic [31:0] genomic_position,
	output logic [1:0]  map_status
);
	import eil_pkg::*;

	localparam int AW   = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
	localparam int CNTW = $clog2(MAX_EXONS + 1);
	localparam int KW   = AW + 34;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SECTOR = 5'b00010,
		ST_SEARCH = 5'b00100,
		ST_SPAN   = 5'b01000,
		ST_HOLD   = 5'b10000
	} state_t;

	// Configuration registers.
	logic        reverse_q;
	logic [7:0]  chrom_q;
	logic [31:0] tx_start_q;
	logic [31:0] tx_end_q;
	logic [31:0] cds_start_q;
	logic [31:0] cds_end_q;
	logic [9:0]  exon_count_q;

	state_t state_q;

	// Exon table, one word per exon holding start in the upper half and end below.
	logic [63:0] exon_mem [MAX_EXONS];

	// Walk address generator and the registered read stage.
	logic [AW-1:0]   iss_addr_q;
	logic [CNTW-1:0] iss_left_q;
	logic [CNTW-1:0] iss_k_q;
	logic            rd_vld_s1;
	logic [63:0]     rd_data_s1;
	logic [AW-1:0]   rd_addr_s1;
	logic [CNTW-1:0] rd_k_s1;

	// Per-query working registers.
	logic [31:0]    pos_q;
	logic [31:0]    idx_q;
	logic [KW-1:0]  k_q;
	logic           first_q;
	logic [31:0]    prev_q;
	logic           intron_hit_q;
	logic [9:0]     intron_num_q;

	// Pending result and output register.
	logic [2:0]  res_kind_q;
	logic [9:0]  res_num_q;
	logic [31:0] res_gpos_q;
	logic [1:0]  res_status_q;
	logic        result_valid_q;
	logic [2:0]  out_kind_q;
	logic [9:0]  out_num_q;
	logic [31:0] out_gpos_q;
	logic [1:0]  out_status_q;

	logic [CNTW-1:0] live_n;
	logic            accept;
	logic            mem_we;
	logic [AW-1:0]   wr_addr;
	logic            front_done;
	logic [2:0]      front_kind;
	logic [31:0]     rd_start;
	logic [31:0]     rd_end;
	logic            walking;
	logic            exon_hit;
	logic            search_hit;
	logic            span_fit;
	logic            drained;
	logic            issue_en;
	logic            out_free;
	step_req_t       req;
	step_rsp_t       rsp;
	logic [KW-1:0]   k_next;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q    <= 1'b0;
			chrom_q      <= '0;
			tx_start_q   <= '0;
			tx_end_q     <= '0;
			cds_start_q  <= '0;
			cds_end_q    <= '0;
			exon_count_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_REVERSE:    reverse_q    <= cfg_data[0];
				CFG_CHROM:      chrom_q      <= cfg_data[7:0];
				CFG_TX_START:   tx_start_q   <= cfg_data;
				CFG_TX_END:     tx_end_q     <= cfg_data;
				CFG_CDS_START:  cds_start_q  <= cfg_data;
				CFG_CDS_END:    cds_end_q    <= cfg_data;
				CFG_EXON_COUNT: exon_count_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// The walk never goes past the table, whatever the programmed count.
	assign live_n = (32'(exon_count_q) > 32'(MAX_EXONS)) ? CNTW'(MAX_EXONS)
	                                                      : CNTW'(exon_count_q);

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign mem_we     = accept && (func == FUNC_LOAD) && (32'(exon_slot) < 32'(MAX_EXONS));
	assign wr_addr    = AW'(exon_slot);

	// Chromosome and transcript-bound checks settle a sector query at once.
	always_comb begin
		front_done = 1'b1;
		front_kind = KIND_NONE;
		if (query_chrom != chrom_q) begin
			front_kind = KIND_NONE;
		end else if (query_position > tx_end_q) begin
			front_kind = reverse_q ? KIND_FIVE : KIND_THREE;
		end else if (query_position <= tx_start_q) begin
			front_kind = reverse_q ? KIND_THREE : KIND_FIVE;
		end else begin
			front_done = 1'b0;
		end
	end

	// Table memory: one write port for loads, one registered read port for the walk.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			exon_mem[wr_addr] <= {exon_begin, exon_finish};
		end
		if (issue_en) begin
			rd_data_s1 <= exon_mem[iss_addr_q];
			rd_addr_s1 <= iss_addr_q;
			rd_k_s1    <= iss_k_q;
		end
	end

	assign rd_start = rd_data_s1[63:32];
	assign rd_end   = rd_data_s1[31:0];

	// Operand selection for the shared step unit. In a sector walk window A is
	// the exon itself and window B the intron between it and the previous exon
	// in strand order; the coding search tests the coding start against window
	// A; the coding walk measures spans from window A's bounds.
	always_comb begin
		req.point = {1'b0, pos_q};
		req.a_lo  = rd_start;
		req.a_hi  = rd_end;
		req.b_lo  = reverse_q ? rd_end : prev_q;
		req.b_hi  = reverse_q ? prev_q : rd_start;
		unique case (state_q)
			ST_SEARCH: begin
				// Forward tests start <= cds_start < end as a half-open window.
				req.point = reverse_q ? {1'b0, cds_end_q} : ({1'b0, cds_start_q} + 33'd1);
			end
			ST_SPAN: begin
				// The first exon is cut at the coding start or end.
				req.a_lo = (first_q && !reverse_q) ? cds_start_q : rd_start;
				req.a_hi = (first_q && reverse_q) ? cds_end_q : rd_end;
			end
			default: ;
		endcase
	end

	eil_step_unit #(
		.KW(KW)
	) u_step (
		.req   (req),
		.k     (k_q),
		.rsp   (rsp),
		.k_next(k_next)
	);

	assign walking    = (state_q == ST_SECTOR) || (state_q == ST_SEARCH) || (state_q == ST_SPAN);
	assign exon_hit   = (state_q == ST_SECTOR) && rd_vld_s1 && rsp.hit_a;
	assign search_hit = (state_q == ST_SEARCH) && rd_vld_s1 && rsp.hit_a;
	assign span_fit   = (state_q == ST_SPAN) && rd_vld_s1 && rsp.fits;
	assign drained    = (iss_left_q == '0) && !rd_vld_s1;
	assign issue_en   = walking && (iss_left_q != '0) && !exon_hit && !search_hit && !span_fit;
	assign out_free   = !result_valid_q || !result_stall;

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rd_vld_s1      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_en;
			if ((state_q == ST_HOLD) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (func == FUNC_SECTOR) begin
							state_q <= front_done ? ST_HOLD : ST_SECTOR;
						end else if (func == FUNC_CODING) begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SECTOR: begin
					if (exon_hit || drained) begin
						state_q <= ST_HOLD;
					end
				end
				ST_SEARCH: begin
					if (search_hit) begin
						state_q <= (idx_q == '0) ? ST_HOLD : ST_SPAN;
					end else if (drained) begin
						state_q <= ST_HOLD;
					end
				end
				ST_SPAN: begin
					if (span_fit || drained) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Walk datapath and result registers.
	always_ff @(posedge clk) begin
		if (issue_en) begin
			iss_addr_q <= reverse_q ? (iss_addr_q - AW'(1)) : (iss_addr_q + AW'(1));
			iss_left_q <= iss_left_q - CNTW'(1);
			iss_k_q    <= iss_k_q + CNTW'(1);
		end

		if (accept) begin
			pos_q        <= query_position;
			idx_q        <= coding_index;
			iss_addr_q   <= reverse_q ? AW'(live_n - CNTW'(1)) : '0;
			iss_left_q   <= live_n;
			iss_k_q      <= '0;
			intron_hit_q <= 1'b0;
			res_kind_q   <= (func == FUNC_SECTOR) ? front_kind : KIND_NONE;
			res_num_q    <= '0;
			res_gpos_q   <= '0;
			res_status_q <= MAP_OK;
		end

		unique case (state_q)
			ST_SECTOR: begin
				if (rd_vld_s1) begin
					prev_q <= reverse_q ? rd_start : rd_end;
					// Only the first intron in strand order counts; an exon hit wins.
					if (rsp.hit_b && (rd_k_s1 != '0) && !intron_hit_q) begin
						intron_hit_q <= 1'b1;
						intron_num_q <= 10'(rd_k_s1);
					end
					if (rsp.hit_a) begin
						res_kind_q <= KIND_EXON;
						res_num_q  <= 10'(rd_k_s1 + CNTW'(1));
					end
				end else if (drained && intron_hit_q) begin
					res_kind_q <= KIND_INTRON;
					res_num_q  <= intron_num_q;
				end
			end
			ST_SEARCH: begin
				if (search_hit) begin
					if (idx_q == '0) begin
						res_status_q <= MAP_BEYOND;
					end else begin
						// Restart the walk at the exon holding the coding start.
						k_q        <= KW'(idx_q - 32'd1);
						first_q    <= 1'b1;
						iss_addr_q <= rd_addr_s1;
						iss_left_q <= reverse_q ? (CNTW'(rd_addr_s1) + CNTW'(1))
						                        : (live_n - CNTW'(rd_addr_s1));
					end
				end else if (drained) begin
					res_status_q <= MAP_NO_START;
				end
			end
			ST_SPAN: begin
				if (rd_vld_s1) begin
					if (rsp.fits) begin
						res_gpos_q <= reverse_q ? rsp.pos_down : rsp.pos_up;
					end else begin
						k_q     <= k_next;
						first_q <= 1'b0;
					end
				end else if (drained) begin
					res_status_q <= MAP_BEYOND;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					out_kind_q   <= res_kind_q;
					out_num_q    <= res_num_q;
					out_gpos_q   <= res_gpos_q;
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid     = result_valid_q;
	assign region_kind      = out_kind_q;
	assign region_number    = out_num_q;
	assign genomic_position = out_gpos_q;
	assign map_status       = out_status_q;

	// Table reads are only in flight while a walk is running.
	a_read_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SECTOR || state_q == ST_SEARCH || state_q == ST_SPAN))
		else $error("table read outstanding outside a walk");

	// The remaining coding offset never goes negative.
	a_offset_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPAN) |-> !k_q[KW-1])
		else $error("coding offset negative");

	// A region number is given exactly for exons and introns.
	a_number_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		((region_kind == KIND_EXON || region_kind == KIND_INTRON) == (region_number != '0)))
		else $error("region number does not match region kind");

	// A failed coding query reports no position.
	a_status_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && map_status != MAP_OK) |-> (genomic_position == '0))
		else $error("position given with failing status");

	// A load item leaves the sequencer idle.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_LOAD) |=> (state_q == ST_IDLE))
		else $error("load item started a walk");

endmodule
